// ===== sv/bfe_pkg.sv =====
// Shared constants for the bloom filter engine.
package bfe_pkg;

    // Golden-ratio step between successive probes.
    localparam logic [63:0] PROBE_STEP = 64'h9E37_79B9_7F4A_7C15;

    // Remainder unit: 68-bit dividend, 4 bits per cycle.
    localparam int DIV_W      = 68;
    localparam int DIG        = 4;
    localparam int DIV_STEPS  = DIV_W / DIG;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Input beat modes.
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;

    // Register word index (paddr[2]).
    localparam logic REG_FILTER_BITS = 1'b0;
    localparam logic REG_HASH_COUNT  = 1'b1;

    localparam int FILTER_BITS_W = 17;
    localparam int HASH_COUNT_W  = 5;

endpackage

// ===== sv/bfe_rem.sv =====
// Radix-16 restoring remainder unit: computes dividend mod divisor.
module bfe_rem #(
    parameter int NB_W = 17
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bfe_pkg::DIV_W-1:0] dividend,
    input  logic [NB_W-1:0]           divisor,
    output logic                      done,
    output logic [NB_W-1:0]           rem
);

    logic [bfe_pkg::DIV_W-1:0]     dvd_reg;
    logic [NB_W-1:0]               rem_reg;
    logic [NB_W-1:0]               dsr_reg;
    logic [bfe_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [bfe_pkg::DIV_W-1:0] dvd_next;
    logic [NB_W-1:0]           rem_next;

    always_comb
    begin
        logic [NB_W:0] t;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        for (int k = 0; k < bfe_pkg::DIG; k++)
        begin
            t = {rem_next, dvd_next[bfe_pkg::DIV_W-1]};
            if (t >= {1'b0, dsr_reg})
            begin
                t = t - {1'b0, dsr_reg};
            end
            rem_next = t[NB_W-1:0];
            dvd_next = {dvd_next[bfe_pkg::DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == bfe_pkg::DIV_CNT_W'(bfe_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== sv/bloom_filter_engine.sv =====
// Bloom filter engine: double-hash probing over a byte-wide bit store.
//
// A Bloom filter over a MAX_BITS/8-byte store held in one synchronous RAM.
// Each beat carries a precomputed 64-bit key hash; probe i uses bit
// ((key_hash + i*0x9E3779B97F4A7C15) mod 2^64) mod n, with
// n = min(filter_bits, MAX_BITS), probes = min(hash_count, MAX_PROBES).
// Add sets the probe bits, query returns may_contain, load writes one raw
// byte. After reset the block clears the store, one byte per cycle, over
// all MAX_BITS/8 bytes (8192 at the default) with in_stall high; config
// writes still land. An add or query is accepted, then the remainder units
// reduce key_hash, step and 2^64, each mod n, 4 bits per cycle over 17
// steps, and the remainders are picked up; then the probes run at one RAM
// read-modify-write per cycle (last write forwarded), a drain step
// follows, and a query then posts its result. Load, mode 3 and
// empty-filter adds finish on acceptance, and an empty-filter query goes
// straight to posting its result. A finished result waits in the output
// register while the next beat is accepted.
module bloom_filter_engine #(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_PROBES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [63:0] key_hash,
    input  logic [12:0] byte_index,
    input  logic [7:0]  byte_value,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        may_contain,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int STORE_BYTES = MAX_BITS / 8;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int NB_W        = $clog2(MAX_BITS + 1);
    localparam int PW          = $clog2(MAX_PROBES + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_PROBE,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    // ---------------- config registers ----------------
    logic [bfe_pkg::FILTER_BITS_W-1:0] filter_bits_reg;
    logic [bfe_pkg::HASH_COUNT_W-1:0]  hash_count_reg;
    logic                              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_bits_reg <= 17'd65536;
            hash_count_reg  <= 5'd4;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                bfe_pkg::REG_FILTER_BITS: filter_bits_reg <= pwdata[16:0];
                bfe_pkg::REG_HASH_COUNT:  hash_count_reg  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            bfe_pkg::REG_FILTER_BITS: prdata = {15'd0, filter_bits_reg};
            bfe_pkg::REG_HASH_COUNT:  prdata = {27'd0, hash_count_reg};
            default:                  prdata = '0;
        endcase
    end

    // Effective bit count and probe count (clamped).
    logic [NB_W-1:0] nbits;
    logic [PW-1:0]   nprobes;
    logic            empty;

    always_comb
    begin
        if (32'(filter_bits_reg) > MAX_BITS)
        begin
            nbits = NB_W'(MAX_BITS);
        end
        else
        begin
            nbits = NB_W'(filter_bits_reg);
        end
        if (32'(hash_count_reg) > MAX_PROBES)
        begin
            nprobes = PW'(MAX_PROBES);
        end
        else
        begin
            nprobes = PW'(hash_count_reg);
        end
    end

    assign empty = (nbits == '0) || (nprobes == '0);

    // ---------------- control / datapath registers ----------------
    state_t          state_reg;
    logic [AW-1:0]   clr_addr_reg;
    logic            query_reg;     // current item is a query
    logic [63:0]     p_reg;         // running 64-bit probe hash
    logic [NB_W-1:0] r_reg;         // p_reg mod n
    logic [NB_W-1:0] g_reg;         // step mod n
    logic [NB_W-1:0] w_reg;         // 2^64 mod n
    logic [PW-1:0]   cnt_reg;       // probes issued
    logic            hit_reg;
    logic            s2_valid_reg;  // probe waiting on RAM data
    logic [AW-1:0]   s2_addr_reg;
    logic [7:0]      s2_mask_reg;
    logic            lw_valid_reg;  // last probe write, for forwarding
    logic [AW-1:0]   lw_addr_reg;
    logic [7:0]      lw_data_reg;
    logic            out_valid_reg;
    logic            may_contain_reg;

    logic in_accept;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // ---------------- remainder units ----------------
    logic            div_start;
    logic            rh_done;
    logic            rg_done;
    logic            rw_done;
    logic [NB_W-1:0] rh_rem;
    logic [NB_W-1:0] rg_rem;
    logic [NB_W-1:0] rw_rem;

    assign div_start = in_accept && !empty
                       && (mode == bfe_pkg::MODE_ADD || mode == bfe_pkg::MODE_QUERY);

    bfe_rem #(.NB_W(NB_W)) u_rem_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({4'd0, key_hash}),
        .divisor  (nbits),
        .done     (rh_done),
        .rem      (rh_rem)
    );

    bfe_rem #(.NB_W(NB_W)) u_rem_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({4'd0, bfe_pkg::PROBE_STEP}),
        .divisor  (nbits),
        .done     (rg_done),
        .rem      (rg_rem)
    );

    bfe_rem #(.NB_W(NB_W)) u_rem_wrap (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({3'd0, 1'b1, 64'd0}),
        .divisor  (nbits),
        .done     (rw_done),
        .rem      (rw_rem)
    );

    // ---------------- next probe position ----------------
    // r' = (r + g - carry*w) mod n, tracking (p + step) mod 2^64 mod n.
    logic [NB_W:0]   sum_r;
    logic [NB_W-1:0] s1;
    logic [64:0]     p_sum;
    logic [NB_W:0]   wrap_r;
    logic [NB_W-1:0] r_next;

    always_comb
    begin
        sum_r = {1'b0, r_reg} + {1'b0, g_reg};
        if (sum_r >= {1'b0, nbits})
        begin
            sum_r = sum_r - {1'b0, nbits};
        end
        s1     = sum_r[NB_W-1:0];
        p_sum  = {1'b0, p_reg} + {1'b0, bfe_pkg::PROBE_STEP};
        wrap_r = {1'b0, s1};
        if (p_sum[64])
        begin
            if (s1 >= w_reg)
            begin
                wrap_r = {1'b0, s1} - {1'b0, w_reg};
            end
            else
            begin
                wrap_r = {1'b0, s1} + {1'b0, nbits} - {1'b0, w_reg};
            end
        end
        r_next = wrap_r[NB_W-1:0];
    end

    // ---------------- bit store RAM ----------------
    logic [7:0]    mem [STORE_BYTES];
    logic [7:0]    mem_q;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wa;
    logic [7:0]    wd;
    logic [7:0]    s2_data;
    logic          load_ok;

    assign rd_addr = r_reg[AW+2:3];
    assign s2_data = (lw_valid_reg && lw_addr_reg == s2_addr_reg) ? lw_data_reg : mem_q;
    assign load_ok = in_accept && (mode == bfe_pkg::MODE_LOAD)
                     && (32'(byte_index) < STORE_BYTES);

    always_comb
    begin
        we = 1'b0;
        wa = s2_addr_reg;
        wd = s2_data | s2_mask_reg;
        priority if (state_reg == ST_CLEAR)
        begin
            we = 1'b1;
            wa = clr_addr_reg;
            wd = '0;
        end
        else if (load_ok)
        begin
            we = 1'b1;
            wa = AW'(byte_index);
            wd = byte_value;
        end
        else if (s2_valid_reg && !query_reg)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        mem_q <= mem[rd_addr];
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            cnt_reg       <= '0;
            s2_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // output register: load a posted result, else drop a taken beat
            if (state_reg == ST_RESULT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg   <= 1'b1;
                may_contain_reg <= hit_reg;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // second probe stage: RAM data is back
            if (s2_valid_reg)
            begin
                if (query_reg)
                begin
                    if ((s2_data & s2_mask_reg) == '0)
                    begin
                        hit_reg <= 1'b0;
                    end
                end
                else
                begin
                    lw_valid_reg <= 1'b1;
                    lw_addr_reg  <= s2_addr_reg;
                    lw_data_reg  <= s2_data | s2_mask_reg;
                end
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == AW'(STORE_BYTES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        query_reg    <= (mode == bfe_pkg::MODE_QUERY);
                        p_reg        <= key_hash;
                        hit_reg      <= 1'b1;
                        cnt_reg      <= '0;
                        lw_valid_reg <= 1'b0;
                        if (div_start)
                        begin
                            state_reg <= ST_DIV;
                        end
                        else if (mode == bfe_pkg::MODE_QUERY)
                        begin
                            state_reg <= ST_RESULT;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (rh_done)
                    begin
                        r_reg     <= rh_rem;
                        g_reg     <= rg_rem;
                        w_reg     <= rw_rem;
                        state_reg <= ST_PROBE;
                    end
                end
                ST_PROBE:
                begin
                    s2_valid_reg <= 1'b1;
                    s2_addr_reg  <= rd_addr;
                    s2_mask_reg  <= 8'd1 << r_reg[2:0];
                    r_reg        <= r_next;
                    p_reg        <= p_sum[63:0];
                    cnt_reg      <= cnt_reg + 1'b1;
                    if (cnt_reg == nprobes - 1'b1)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    s2_valid_reg <= 1'b0;
                    state_reg    <= query_reg ? ST_RESULT : ST_IDLE;
                end
                ST_RESULT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign may_contain = may_contain_reg;

    // ---------------- assertions ----------------
    a_s2_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (state_reg == ST_PROBE || state_reg == ST_DRAIN))
        else $error("probe stage active outside probe sequence");

    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (query_reg && (state_reg == ST_PROBE || state_reg == ST_DRAIN)) |-> !we)
        else $error("store written during a query");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        rh_done |-> (rg_done && rw_done))
        else $error("remainder units out of step");

    a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && !query_reg) |=> state_reg == ST_IDLE)
        else $error("add sequence did not return to idle");

endmodule
